[hdl/bha_pkg.sv]
// bha_pkg: shared types and constants for the block heap allocator.
// No dependencies.
package bha_pkg;

   localparam int HeapBytesDefault = 512;
   localparam int MaxBlocksDefault = 16;
   localparam int HeapBytesCeiling = 65536;

   localparam logic [2:0] KIND_BUMP  = 3'd0;
   localparam logic [2:0] KIND_FIRST = 3'd1;
   localparam logic [2:0] KIND_BEST  = 3'd2;
   localparam logic [2:0] KIND_SPLIT = 3'd3;
   localparam logic [2:0] KIND_FREE  = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_USED   = 2'd3;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_REJECT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_UP,
      S_MERGE_R,
      S_MERGE_L,
      S_STATS,
      S_OUT
   } state_type;

endpackage

[hdl/bha_front.sv]
// bha_front: accepts requests, classifies them and queues them for the engine.
// Depends on bha_pkg.
module bha_front #(
   parameter int SizeW = 10,
   parameter int AddrW = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [2:0]          in_kind,
   input  logic [SizeW-1:0]    in_size,
   input  logic [AddrW-1:0]    in_addr,
   output logic                q_valid,
   input  logic                q_ready,
   output bha_pkg::op_type     q_op,
   output logic [2:0]          q_kind,
   output logic [SizeW-1:0]    q_size,
   output logic [AddrW-1:0]    q_addr
);

   // two-entry queue
   logic [1:0]            vld_ff, vld_in;
   bha_pkg::op_type       op_ff [2];
   logic [2:0]            kind_ff [2];
   logic [SizeW-1:0]      size_ff [2];
   logic [AddrW-1:0]      addr_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   bha_pkg::op_type       cls;
   logic                  push, pop;

   always_comb begin
      if (in_kind == bha_pkg::KIND_FREE) begin
         cls = bha_pkg::OP_FREE;
      end else if (in_kind > bha_pkg::KIND_FREE || in_size == '0) begin
         cls = bha_pkg::OP_REJECT;
      end else begin
         cls = bha_pkg::OP_ALLOC;
      end
   end

   assign in_ready = !vld_ff[wr_ptr_ff];
   assign push     = in_valid && in_ready;
   assign q_valid  = vld_ff[rd_ptr_ff];
   assign pop      = q_valid && q_ready;
   assign q_op     = op_ff[rd_ptr_ff];
   assign q_kind   = kind_ff[rd_ptr_ff];
   assign q_size   = size_ff[rd_ptr_ff];
   assign q_addr   = addr_ff[rd_ptr_ff];

   always_comb begin
      vld_in    = vld_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         vld_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in         = !rd_ptr_ff;
      end
      if (push) begin
         vld_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in         = !wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= cls;
         kind_ff[wr_ptr_ff] <= in_kind;
         size_ff[wr_ptr_ff] <= in_size;
         addr_ff[wr_ptr_ff] <= in_addr;
      end
   end

endmodule

[hdl/bha_engine.sv]
// bha_engine: block table and sequencer that carries out allocations and frees.
// Depends on bha_pkg.
module bha_engine #(
   parameter int HeapBytes = bha_pkg::HeapBytesDefault,
   parameter int MaxBlocks = bha_pkg::MaxBlocksDefault,
   parameter int SizeW     = 10,
   parameter int AddrW     = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  bha_pkg::op_type    q_op,
   input  logic [2:0]         q_kind,
   input  logic [SizeW-1:0]   q_size,
   input  logic [AddrW-1:0]   q_addr,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [1:0]         out_status,
   output logic [AddrW-1:0]   out_address,
   output logic [SizeW-1:0]   out_size,
   output logic [SizeW-1:0]   out_in_use,
   output logic [SizeW-1:0]   out_largest
);

   localparam int IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
   localparam int CntW = $clog2(MaxBlocks + 1);
   localparam int SumW = SizeW + 1;
   localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBlocks);
   localparam logic [SumW-1:0] HeapLim = SumW'(HeapBytes);

   // table rows, read by the scan index, the selected entry and the last entry
   logic [AddrW-1:0] start_ff [MaxBlocks];
   logic [SizeW-1:0] bytes_ff [MaxBlocks];
   logic [MaxBlocks-1:0] used_ff;

   bha_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]  count_ff;
   logic [SizeW-1:0] total_ff;
   logic [CntW-1:0]  ptr_ff;     // scan / shift index
   logic [IdxW-1:0]  hit_ff;     // selected entry
   logic             found_ff;
   bha_pkg::op_type  op_ff;
   logic [2:0]       kind_ff;
   logic [SizeW-1:0] size_ff;
   logic [AddrW-1:0] addr_ff;
   logic [1:0]       status_ff;
   logic [SizeW-1:0] largest_ff;
   logic             ovld_ff;
   logic [1:0]       ost_ff;
   logic [AddrW-1:0] oaddr_ff;
   logic [SizeW-1:0] osize_ff, ouse_ff, olarge_ff;

   logic [IdxW-1:0]  p;
   logic [IdxW-1:0]  lastx;
   logic [SumW-1:0]  tail_end;
   logic             fits;
   logic             merge_r_ok, merge_l_ok, do_split;

   assign p        = ptr_ff[IdxW-1:0];
   assign lastx    = IdxW'(count_ff - CntW'(1));
   assign tail_end = (count_ff == '0) ? '0 :
                     SumW'(start_ff[lastx]) + SumW'(bytes_ff[lastx]);
   assign fits     = !used_ff[p] && bytes_ff[p] >= size_ff;

   // free neighbors of the selected entry, and a split that has table room
   assign merge_r_ok = (CntW'(hit_ff) + CntW'(1) < count_ff) &&
                       !used_ff[hit_ff + IdxW'(1)];
   assign merge_l_ok = (hit_ff != '0) && !used_ff[hit_ff - IdxW'(1)];
   assign do_split   = op_ff == bha_pkg::OP_ALLOC && found_ff &&
                       kind_ff == bha_pkg::KIND_SPLIT && bytes_ff[hit_ff] > size_ff &&
                       count_ff < MaxCnt;

   assign q_ready     = (state_ff == bha_pkg::S_IDLE);
   assign out_valid   = ovld_ff;
   assign out_status  = ost_ff;
   assign out_address = oaddr_ff;
   assign out_size    = osize_ff;
   assign out_in_use  = ouse_ff;
   assign out_largest = olarge_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bha_pkg::S_IDLE:   if (q_valid) state_in = (q_op == bha_pkg::OP_REJECT) ?
                                                   bha_pkg::S_STATS : bha_pkg::S_SCAN;
         bha_pkg::S_SCAN:   if (ptr_ff >= count_ff ||
                                (op_ff == bha_pkg::OP_FREE && start_ff[p] == addr_ff &&
                                 used_ff[p]) ||
                                (op_ff == bha_pkg::OP_ALLOC && fits &&
                                 kind_ff != bha_pkg::KIND_BEST &&
                                 kind_ff != bha_pkg::KIND_BUMP))
                               state_in = bha_pkg::S_DECIDE;
         bha_pkg::S_DECIDE: begin
            if (do_split) state_in = bha_pkg::S_SHIFT_UP;
            else if (op_ff == bha_pkg::OP_FREE && found_ff) state_in = bha_pkg::S_MERGE_R;
            else state_in = bha_pkg::S_STATS;
         end
         bha_pkg::S_SHIFT_UP: if (ptr_ff <= CntW'(hit_ff) + CntW'(1))
                                 state_in = bha_pkg::S_STATS;
         bha_pkg::S_MERGE_R: if (ptr_ff == '0 && !merge_r_ok) state_in = bha_pkg::S_MERGE_L;
         bha_pkg::S_MERGE_L: if (ptr_ff == '0 && !merge_l_ok) state_in = bha_pkg::S_STATS;
         bha_pkg::S_STATS:  if (ptr_ff >= count_ff) state_in = bha_pkg::S_OUT;
         bha_pkg::S_OUT:    if (!ovld_ff || out_ready) state_in = bha_pkg::S_IDLE;
         default:           state_in = bha_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bha_pkg::S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         used_ff  <= '0;
         ovld_ff  <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bha_pkg::S_OUT && (!ovld_ff || out_ready)) ovld_ff <= 1'b1;
         else if (out_ready) ovld_ff <= 1'b0;
         case (state_ff)
            bha_pkg::S_IDLE: begin
               ptr_ff <= '0;
               if (q_valid) begin
                  op_ff      <= q_op;
                  kind_ff    <= q_kind;
                  size_ff    <= q_size;
                  addr_ff    <= q_addr;
                  found_ff   <= 1'b0;
                  status_ff  <= (q_op == bha_pkg::OP_FREE) ? bha_pkg::ST_NOT_USED :
                                                              bha_pkg::ST_NO_SPACE;
                  largest_ff <= '0;
               end
            end
            bha_pkg::S_SCAN: begin
               if (ptr_ff < count_ff) begin
                  if (op_ff == bha_pkg::OP_FREE) begin
                     if (start_ff[p] == addr_ff && used_ff[p]) begin
                        found_ff <= 1'b1;
                        hit_ff   <= p;
                     end
                  end else if (kind_ff != bha_pkg::KIND_BUMP && fits &&
                               (!found_ff || bytes_ff[p] < bytes_ff[hit_ff])) begin
                     found_ff <= 1'b1;
                     hit_ff   <= p;
                  end
                  ptr_ff <= ptr_ff + CntW'(1);
               end
            end
            bha_pkg::S_DECIDE: begin
               ptr_ff <= do_split ? count_ff : '0;
               if (op_ff == bha_pkg::OP_FREE) begin
                  if (found_ff) begin
                     used_ff[hit_ff] <= 1'b0;
                     total_ff  <= total_ff - bytes_ff[hit_ff];
                     status_ff <= bha_pkg::ST_OK;
                  end
               end else if (found_ff) begin
                  status_ff <= bha_pkg::ST_OK;
                  used_ff[hit_ff] <= 1'b1;
                  if (do_split) begin
                     total_ff <= total_ff + size_ff;
                  end else begin
                     total_ff <= total_ff + bytes_ff[hit_ff];
                  end
               end else if (tail_end + SumW'(size_ff) > HeapLim) begin
                  status_ff <= bha_pkg::ST_NO_SPACE;
               end else if (count_ff >= MaxCnt) begin
                  status_ff <= bha_pkg::ST_TABLE_FULL;
               end else begin
                  // append past the last block
                  status_ff <= bha_pkg::ST_OK;
                  start_ff[IdxW'(count_ff)] <= AddrW'(tail_end);
                  bytes_ff[IdxW'(count_ff)] <= size_ff;
                  used_ff[IdxW'(count_ff)]  <= 1'b1;
                  hit_ff   <= IdxW'(count_ff);
                  count_ff <= count_ff + CntW'(1);
                  total_ff <= total_ff + size_ff;
               end
            end
            bha_pkg::S_SHIFT_UP: begin
               // one entry moves up a cycle; the last step writes the remainder
               if (ptr_ff > CntW'(hit_ff) + CntW'(1)) begin
                  start_ff[p] <= start_ff[p - IdxW'(1)];
                  bytes_ff[p] <= bytes_ff[p - IdxW'(1)];
                  used_ff[p]  <= used_ff[p - IdxW'(1)];
                  ptr_ff      <= ptr_ff - CntW'(1);
               end else begin
                  start_ff[p] <= start_ff[hit_ff] + AddrW'(size_ff);
                  bytes_ff[p] <= bytes_ff[hit_ff] - size_ff;
                  used_ff[p]  <= 1'b0;
                  bytes_ff[hit_ff] <= size_ff;
                  count_ff    <= count_ff + CntW'(1);
                  ptr_ff      <= '0;
               end
            end
            bha_pkg::S_MERGE_R: begin
               // absorb the free right neighbor, then close the gap entry by entry
               if (ptr_ff == '0) begin
                  if (merge_r_ok) begin
                     bytes_ff[hit_ff] <= bytes_ff[hit_ff] + bytes_ff[hit_ff + IdxW'(1)];
                     ptr_ff <= CntW'(hit_ff) + CntW'(1);
                  end
               end else if (ptr_ff + CntW'(1) < count_ff) begin
                  start_ff[p] <= start_ff[p + IdxW'(1)];
                  bytes_ff[p] <= bytes_ff[p + IdxW'(1)];
                  used_ff[p]  <= used_ff[p + IdxW'(1)];
                  ptr_ff      <= ptr_ff + CntW'(1);
               end else begin
                  count_ff <= count_ff - CntW'(1);
                  ptr_ff   <= '0;
               end
            end
            bha_pkg::S_MERGE_L: begin
               if (ptr_ff == '0) begin
                  if (merge_l_ok) begin
                     bytes_ff[hit_ff - IdxW'(1)] <=
                        bytes_ff[hit_ff - IdxW'(1)] + bytes_ff[hit_ff];
                     ptr_ff <= CntW'(hit_ff);
                     hit_ff <= hit_ff - IdxW'(1);
                  end
               end else if (ptr_ff + CntW'(1) < count_ff) begin
                  start_ff[p] <= start_ff[p + IdxW'(1)];
                  bytes_ff[p] <= bytes_ff[p + IdxW'(1)];
                  used_ff[p]  <= used_ff[p + IdxW'(1)];
                  ptr_ff      <= ptr_ff + CntW'(1);
               end else begin
                  count_ff <= count_ff - CntW'(1);
                  ptr_ff   <= '0;
               end
            end
            bha_pkg::S_STATS: begin
               if (ptr_ff < count_ff) begin
                  if (!used_ff[p] && bytes_ff[p] > largest_ff) largest_ff <= bytes_ff[p];
                  ptr_ff <= ptr_ff + CntW'(1);
               end
            end
            bha_pkg::S_OUT: begin
               if (!ovld_ff || out_ready) begin
                  ost_ff    <= status_ff;
                  oaddr_ff  <= (status_ff == bha_pkg::ST_OK) ? start_ff[hit_ff] : '0;
                  osize_ff  <= (status_ff == bha_pkg::ST_OK) ? bytes_ff[hit_ff] : '0;
                  ouse_ff   <= total_ff;
                  olarge_ff <= largest_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

[hdl/block_heap_allocator.sv]
// block_heap_allocator: top level, request front end and table engine.
// Depends on bha_pkg, bha_front, bha_engine.
//
// Channel  Dir  Bits          Contents
// req_     in   tuser 3       kind
//               tdata 24      request_size, free_address
// rsp_     out  tdata 48      status, block_address, block_size, bytes_in_use, largest_free
//
// A request runs a serial scan of the table blocks, a table shift on a split or merge,
// and a serial scan for the largest free block; the engine takes no new request until then.
// Reset is synchronous and empties the table. The front queue holds two requests
// while the engine works; the result register holds one transfer under stall.
module block_heap_allocator #(
   parameter int HeapBytes = bha_pkg::HeapBytesDefault,
   parameter int MaxBlocks = bha_pkg::MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] kind
   input  logic [23:0] req_tdata,   // [9:0] request_size, [18:10] free_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [1:0] status, [10:2] block_address, [20:11] block_size,
                                    // [30:21] bytes_in_use, [40:31] largest_free
);

   localparam int SizeW = 10;
   localparam int AddrW = 9;

   logic             q_valid, q_ready;
   bha_pkg::op_type  q_op;
   logic [2:0]       q_kind;
   logic [SizeW-1:0] q_size;
   logic [AddrW-1:0] q_addr;
   logic [1:0]       o_status;
   logic [AddrW-1:0] o_addr;
   logic [SizeW-1:0] o_size, o_use, o_large;

   bha_front #(.SizeW(SizeW), .AddrW(AddrW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_size  (req_tdata[9:0]),
      .in_addr  (req_tdata[18:10]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_op     (q_op),
      .q_kind   (q_kind),
      .q_size   (q_size),
      .q_addr   (q_addr)
   );

   bha_engine #(
      .HeapBytes (HeapBytes),
      .MaxBlocks (MaxBlocks),
      .SizeW     (SizeW),
      .AddrW     (AddrW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_op        (q_op),
      .q_kind      (q_kind),
      .q_size      (q_size),
      .q_addr      (q_addr),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (o_status),
      .out_address (o_addr),
      .out_size    (o_size),
      .out_in_use  (o_use),
      .out_largest (o_large)
   );

   assign rsp_tdata = {7'd0, o_large, o_use, o_size, o_addr, o_status};

endmodule
